// ===== hdl/ilws_pkg.sv =====
package ilws_pkg;

   localparam int DEPTH = 16;
   localparam int VAL_W = 32;
   localparam int TOT_W = 36;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int ACT_W = 4;
   localparam int ST_W  = 3;
   localparam int POS_W = 5;

   localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 4'd0;
   localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 4'd1;
   localparam logic [ACT_W-1:0] ACT_INSERT     = 4'd2;
   localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 4'd3;
   localparam logic [ACT_W-1:0] ACT_POP_BACK   = 4'd4;
   localparam logic [ACT_W-1:0] ACT_REMOVE     = 4'd5;
   localparam logic [ACT_W-1:0] ACT_SEARCH     = 4'd6;
   localparam logic [ACT_W-1:0] ACT_READ       = 4'd7;
   localparam logic [ACT_W-1:0] ACT_CLEAR      = 4'd8;

   localparam logic [ST_W-1:0] ST_OK    = 3'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 3'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 3'd3;
   localparam logic [ST_W-1:0] ST_MISS  = 3'd4;

   typedef struct packed {
      logic [CNT_W-1:0] idx;
      logic [VAL_W-1:0] lo;
      logic [VAL_W-1:0] hi;
      logic [VAL_W-1:0] sel;
      logic             hit;
      logic [IDX_W-1:0] fpos;
   } tok_type;

   typedef struct packed {
      logic [CNT_W-1:0] occ;
      logic [VAL_W-1:0] key;
      logic [CNT_W-1:0] tgt;
   } scan_type;

   typedef struct packed {
      logic             ins;
      logic             rem;
      logic [CNT_W-1:0] pos;
      logic [VAL_W-1:0] val;
   } cmd_type;

endpackage

// ===== hdl/ilws_cell.sv =====
module ilws_cell (
   input  logic                      clock,
   input  logic [ilws_pkg::IDX_W-1:0] my_idx,
   input  logic [ilws_pkg::VAL_W-1:0] left_val,
   input  logic [ilws_pkg::VAL_W-1:0] right_val,
   input  ilws_pkg::cmd_type         cmd,
   input  ilws_pkg::scan_type        scan,
   input  ilws_pkg::tok_type         tok_in,
   output logic [ilws_pkg::VAL_W-1:0] value,
   output ilws_pkg::tok_type         tok_out
);

   logic [ilws_pkg::VAL_W-1:0] val_ff, val_in;
   ilws_pkg::tok_type          tok_ff, tok_in_nx;
   logic [ilws_pkg::CNT_W-1:0] me;
   logic                       used;

   assign me = ilws_pkg::CNT_W'(my_idx);

   always_comb begin
      val_in = val_ff;
      if (cmd.ins && me > cmd.pos) begin
         val_in = left_val;
      end else if (cmd.ins && me == cmd.pos) begin
         val_in = cmd.val;
      end else if (cmd.rem && me >= cmd.pos) begin
         val_in = right_val;
      end
   end

   // token walks one cell per cycle, folding this cell in
   always_comb begin
      used      = tok_in.idx < scan.occ;
      tok_in_nx = tok_in;
      tok_in_nx.idx = tok_in.idx + 1'b1;
      if (used) begin
         if (val_ff < tok_in.lo) tok_in_nx.lo = val_ff;
         if (val_ff > tok_in.hi) tok_in_nx.hi = val_ff;
         if (tok_in.idx == scan.tgt) tok_in_nx.sel = val_ff;
         if (!tok_in.hit && val_ff == scan.key) begin
            tok_in_nx.hit  = 1'b1;
            tok_in_nx.fpos = tok_in.idx[ilws_pkg::IDX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
      tok_ff <= tok_in_nx;
   end

   assign value   = val_ff;
   assign tok_out = tok_ff;

endmodule

// ===== hdl/ilws_div.sv =====
module ilws_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [ilws_pkg::TOT_W-1:0] dividend,
   input  logic [ilws_pkg::CNT_W-1:0] divisor,
   output logic                      busy,
   output logic [ilws_pkg::VAL_W-1:0] quotient
);

   localparam int STEP_W = $clog2(ilws_pkg::TOT_W + 1);

   logic                       busy_ff, busy_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic [ilws_pkg::CNT_W-1:0] rem_ff, rem_in;
   logic [ilws_pkg::TOT_W-1:0] quo_ff, quo_in;
   logic [ilws_pkg::CNT_W-1:0] dvs_ff, dvs_in;
   logic [ilws_pkg::CNT_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      trial   = {rem_ff, quo_ff[ilws_pkg::TOT_W-1]};
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = ilws_pkg::CNT_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[ilws_pkg::TOT_W-2:0], 1'b1};
         end else begin
            rem_in = trial[ilws_pkg::CNT_W-1:0];
            quo_in = {quo_ff[ilws_pkg::TOT_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(ilws_pkg::TOT_W - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff[ilws_pkg::VAL_W-1:0];

endmodule

// ===== hdl/indexed_list_with_stats.sv =====
// indexed list with statistics: an ordered list of up to 16 unsigned 32-bit values
// input channel req_*: action, value, position; one beat per action
// result channel rsp_*: one beat per request with status, read or found data and
// count, total, smallest, largest and truncated mean of the list after the action
// one request at a time: a new request is taken only once the last result is in the
// output register; the steps are a scan of the cell row before the update (search,
// read, value to remove), a shift of the cell row, then a scan for min and max running
// beside a restoring divide of the total by the count, which is the longer of the two
// and sets when the result is ready, and a load of the output register
// req_stall is high from the accepted beat until the result is in the output register
// the next request is taken while a finished result waits under rsp_stall; the
// following result waits until that one is taken
// reset empties the list and drops any pending result; cell contents are not cleared
module indexed_list_with_stats (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_action,
   input  logic [31:0] req_value,
   input  logic [4:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_read_value,
   output logic [3:0]  rsp_found_position,
   output logic [4:0]  rsp_count,
   output logic [35:0] rsp_total,
   output logic [31:0] rsp_smallest,
   output logic [31:0] rsp_largest,
   output logic [31:0] rsp_mean
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_PRE   = 5'b00010,
      S_APPLY = 5'b00100,
      S_POST  = 5'b01000,
      S_WAIT  = 5'b10000
   } state_type;

   localparam int N = ilws_pkg::DEPTH;

   state_type                        state_ff, state_in;
   logic [ilws_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ilws_pkg::CNT_W-1:0]       occ_ff, occ_in;
   logic [ilws_pkg::TOT_W-1:0]       tot_ff, tot_in;
   logic [ilws_pkg::ACT_W-1:0]       act_ff;
   logic [ilws_pkg::VAL_W-1:0]       key_ff;
   logic [ilws_pkg::POS_W-1:0]       pos_ff;
   logic [ilws_pkg::ST_W-1:0]        st_ff, st_in;
   logic [ilws_pkg::VAL_W-1:0]       rd_ff, rd_in;
   logic [ilws_pkg::IDX_W-1:0]       fp_ff, fp_in;
   logic [ilws_pkg::VAL_W-1:0]       lo_ff, hi_ff;
   logic                             rv_ff, rv_in;
   logic [ilws_pkg::ST_W-1:0]        ost_ff;
   logic [ilws_pkg::VAL_W-1:0]       ord_ff, olo_ff, ohi_ff, omean_ff;
   logic [ilws_pkg::IDX_W-1:0]       ofp_ff;
   logic [ilws_pkg::CNT_W-1:0]       ocnt_ff;
   logic [ilws_pkg::TOT_W-1:0]       otot_ff;

   logic [ilws_pkg::CNT_W-1:0]       pos_eff;
   logic                             ins_ok, rem_ok, load;
   logic                             div_busy;
   logic [ilws_pkg::VAL_W-1:0]       quot;
   ilws_pkg::cmd_type                cmd;
   ilws_pkg::scan_type               scan;
   ilws_pkg::tok_type                toks [N+1];
   logic [ilws_pkg::VAL_W-1:0]       cell_val [N];

   assign toks[0] = '{idx: '0, lo: '1, hi: '0, sel: '0, hit: 1'b0, fpos: '0};

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic [ilws_pkg::VAL_W-1:0] lv, rv;
      if (i == 0) begin : g_head
         assign lv = '0;
      end else begin : g_body
         assign lv = cell_val[i-1];
      end
      if (i == N - 1) begin : g_tail
         assign rv = cell_val[i];
      end else begin : g_mid
         assign rv = cell_val[i+1];
      end
      ilws_cell u_cell (
         .clock     (clock),
         .my_idx    (ilws_pkg::IDX_W'(i)),
         .left_val  (lv),
         .right_val (rv),
         .cmd       (cmd),
         .scan      (scan),
         .tok_in    (toks[i]),
         .value     (cell_val[i]),
         .tok_out   (toks[i+1])
      );
   end

   ilws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == S_POST && cnt_ff == '0),
      .dividend (tot_ff),
      .divisor  (occ_ff),
      .busy     (div_busy),
      .quotient (quot)
   );

   always_comb begin
      case (act_ff)
         ilws_pkg::ACT_PUSH_FRONT, ilws_pkg::ACT_POP_FRONT: pos_eff = '0;
         ilws_pkg::ACT_PUSH_BACK: pos_eff = occ_ff;
         ilws_pkg::ACT_POP_BACK:  pos_eff = occ_ff - 1'b1;
         default:                 pos_eff = ilws_pkg::CNT_W'(pos_ff);
      endcase
   end

   assign scan = '{occ: occ_ff, key: key_ff, tgt: pos_eff};

   always_comb begin
      st_in  = ilws_pkg::ST_OK;
      rd_in  = '0;
      fp_in  = '0;
      ins_ok = 1'b0;
      rem_ok = 1'b0;
      unique case (act_ff) inside
         [ilws_pkg::ACT_PUSH_FRONT:ilws_pkg::ACT_INSERT]: begin
            if (occ_ff == ilws_pkg::CNT_W'(N)) st_in = ilws_pkg::ST_FULL;
            else if (pos_eff > occ_ff)         st_in = ilws_pkg::ST_RANGE;
            else                               ins_ok = 1'b1;
         end
         [ilws_pkg::ACT_POP_FRONT:ilws_pkg::ACT_REMOVE]: begin
            if (occ_ff == '0)            st_in = ilws_pkg::ST_EMPTY;
            else if (pos_eff >= occ_ff)  st_in = ilws_pkg::ST_RANGE;
            else                         rem_ok = 1'b1;
         end
         ilws_pkg::ACT_SEARCH: begin
            if (toks[N].hit) begin
               rd_in = key_ff;
               fp_in = toks[N].fpos;
            end else begin
               st_in = ilws_pkg::ST_MISS;
            end
         end
         ilws_pkg::ACT_READ: begin
            if (occ_ff == '0)            st_in = ilws_pkg::ST_EMPTY;
            else if (pos_eff >= occ_ff)  st_in = ilws_pkg::ST_RANGE;
            else                         rd_in = toks[N].sel;
         end
         default: ;
      endcase
   end

   assign cmd = '{ins: state_ff == S_APPLY && ins_ok,
                  rem: state_ff == S_APPLY && rem_ok,
                  pos: pos_eff, val: key_ff};

   assign load = state_ff == S_WAIT && !div_busy && (!rv_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 1'b1;
      occ_in   = occ_ff;
      tot_in   = tot_ff;
      rv_in    = rv_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            cnt_in = '0;
            if (req_valid) state_in = S_PRE;
         end
         S_PRE: begin
            if (cnt_ff == ilws_pkg::CNT_W'(N)) state_in = S_APPLY;
         end
         S_APPLY: begin
            cnt_in   = '0;
            state_in = S_POST;
            if (ins_ok) begin
               occ_in = occ_ff + 1'b1;
               tot_in = tot_ff + ilws_pkg::TOT_W'(key_ff);
            end else if (rem_ok) begin
               occ_in = occ_ff - 1'b1;
               tot_in = tot_ff - ilws_pkg::TOT_W'(toks[N].sel);
            end else if (act_ff == ilws_pkg::ACT_CLEAR) begin
               occ_in = '0;
               tot_in = '0;
            end
         end
         S_POST: begin
            if (cnt_ff == ilws_pkg::CNT_W'(N)) state_in = S_WAIT;
         end
         S_WAIT: begin
            if (load) begin
               state_in = S_IDLE;
               rv_in    = 1'b1;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         occ_ff   <= '0;
         tot_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         occ_ff   <= occ_in;
         tot_ff   <= tot_in;
         rv_ff    <= rv_in;
      end
      if (state_ff == S_IDLE) begin
         act_ff <= req_action;
         key_ff <= req_value[ilws_pkg::VAL_W-1:0];
         pos_ff <= req_position;
      end
      if (state_ff == S_APPLY) begin
         st_ff <= st_in;
         rd_ff <= rd_in;
         fp_ff <= fp_in;
      end
      if (state_ff == S_POST && cnt_ff == ilws_pkg::CNT_W'(N)) begin
         lo_ff <= toks[N].lo;
         hi_ff <= toks[N].hi;
      end
      if (load) begin
         ost_ff   <= st_ff;
         ord_ff   <= rd_ff;
         ofp_ff   <= fp_ff;
         ocnt_ff  <= occ_ff;
         otot_ff  <= tot_ff;
         olo_ff   <= (occ_ff == '0) ? '0 : lo_ff;
         ohi_ff   <= (occ_ff == '0) ? '0 : hi_ff;
         omean_ff <= (occ_ff == '0) ? '0 : quot;
      end
   end

   assign req_stall          = state_ff != S_IDLE;
   assign rsp_valid          = rv_ff;
   assign rsp_status         = ost_ff;
   assign rsp_read_value     = ord_ff;
   assign rsp_found_position = ofp_ff;
   assign rsp_count          = ocnt_ff;
   assign rsp_total          = otot_ff;
   assign rsp_smallest       = olo_ff;
   assign rsp_largest        = ohi_ff;
   assign rsp_mean           = omean_ff;

endmodule

// ===== hdl/ilws_checker.sv =====
module ilws_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_count,
   input logic [35:0] rsp_total,
   input logic [31:0] rsp_smallest,
   input logic [31:0] rsp_largest,
   input logic [31:0] rsp_mean
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_count))
      else $error("result beat dropped or changed under stall");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while busy");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == 5'd0 |-> rsp_total == 36'd0 && rsp_smallest == 32'd0
         && rsp_largest == 32'd0 && rsp_mean == 32'd0)
      else $error("nonzero statistics on empty list");

   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count != 5'd0 |-> rsp_smallest <= rsp_mean
         && rsp_mean <= rsp_largest && rsp_count <= 5'd16)
      else $error("mean outside min and max");

endmodule

bind indexed_list_with_stats ilws_checker u_ilws_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_count    (rsp_count),
   .rsp_total    (rsp_total),
   .rsp_smallest (rsp_smallest),
   .rsp_largest  (rsp_largest),
   .rsp_mean     (rsp_mean)
);

// ===== tb/ilws_checker.sv =====
module tb_ilws_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [3:0]  req_action,
   input  logic [31:0] req_value,
   input  logic [4:0]  req_position,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [31:0] rsp_read_value,
   input  logic [3:0]  rsp_found_position,
   input  logic [4:0]  rsp_count,
   input  logic [35:0] rsp_total,
   input  logic [31:0] rsp_smallest,
   input  logic [31:0] rsp_largest,
   input  logic [31:0] rsp_mean,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] read_value;
      logic [3:0]  found_position;
      logic [4:0]  count;
      logic [35:0] total;
      logic [31:0] smallest;
      logic [31:0] largest;
      logic [31:0] mean;
   } summary_type;

   logic [31:0]  list_cells [ilws_pkg::DEPTH];
   int           list_len;
   logic [35:0]  list_sum;
   summary_type  summary_q[$];

   function automatic summary_type apply_action(logic [3:0] act, logic [31:0] v,
                                                logic [4:0] pos);
      summary_type s;
      int idx;
      s = '0;
      s.status = ilws_pkg::ST_OK;
      case (act)
         ilws_pkg::ACT_PUSH_FRONT, ilws_pkg::ACT_PUSH_BACK, ilws_pkg::ACT_INSERT: begin
            idx = (act == ilws_pkg::ACT_PUSH_FRONT) ? 0 :
                  (act == ilws_pkg::ACT_PUSH_BACK) ? list_len : int'(pos);
            if (list_len >= ilws_pkg::DEPTH) s.status = ilws_pkg::ST_FULL;
            else if (idx > list_len) s.status = ilws_pkg::ST_RANGE;
            else begin
               for (int k = list_len; k > idx; k--) list_cells[k] = list_cells[k-1];
               list_cells[idx] = v;
               list_len++;
               list_sum = list_sum + 36'(v);
            end
         end
         ilws_pkg::ACT_POP_FRONT, ilws_pkg::ACT_POP_BACK, ilws_pkg::ACT_REMOVE: begin
            idx = (act == ilws_pkg::ACT_POP_FRONT) ? 0 :
                  (act == ilws_pkg::ACT_POP_BACK) ? list_len - 1 : int'(pos);
            if (list_len == 0) s.status = ilws_pkg::ST_EMPTY;
            else if (idx >= list_len) s.status = ilws_pkg::ST_RANGE;
            else begin
               list_sum = list_sum - 36'(list_cells[idx]);
               for (int k = idx; k + 1 < list_len; k++) list_cells[k] = list_cells[k+1];
               list_len--;
            end
         end
         ilws_pkg::ACT_SEARCH: begin
            s.status = ilws_pkg::ST_MISS;
            for (int k = 0; k < list_len; k++)
               if (s.status == ilws_pkg::ST_MISS && list_cells[k] == v) begin
                  s.status = ilws_pkg::ST_OK;
                  s.read_value = v;
                  s.found_position = 4'(k);
               end
         end
         ilws_pkg::ACT_READ: begin
            if (list_len == 0) s.status = ilws_pkg::ST_EMPTY;
            else if (int'(pos) >= list_len) s.status = ilws_pkg::ST_RANGE;
            else s.read_value = list_cells[pos];
         end
         ilws_pkg::ACT_CLEAR: begin
            list_len = 0;
            list_sum = '0;
         end
         default: ;
      endcase
      s.count = 5'(list_len);
      s.total = list_sum;
      if (list_len > 0) begin
         s.smallest = list_cells[0];
         s.largest = list_cells[0];
         for (int k = 1; k < list_len; k++) begin
            if (list_cells[k] < s.smallest) s.smallest = list_cells[k];
            if (list_cells[k] > s.largest) s.largest = list_cells[k];
         end
         s.mean = 32'(list_sum / 36'(list_len));
      end
      return s;
   endfunction

   always @(posedge clock) begin
      summary_type want, got;
      if (reset) begin
         list_len = 0;
         list_sum = '0;
         summary_q.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_status, rsp_read_value, rsp_found_position, rsp_count,
                    rsp_total, rsp_smallest, rsp_largest, rsp_mean};
            if (summary_q.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, got);
               fail_count++;
            end else begin
               want = summary_q[0];
               summary_q.delete(0);
               if (got.status != want.status)
                  $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
               if (got.read_value != want.read_value)
                  $display("%0t: read_value exp %h got %h", $time, want.read_value,
                           got.read_value);
               if (got.found_position != want.found_position)
                  $display("%0t: found_position exp %0d got %0d", $time,
                           want.found_position, got.found_position);
               if (got.count != want.count)
                  $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
               if (got.total != want.total)
                  $display("%0t: total exp %h got %h", $time, want.total, got.total);
               if (got.smallest != want.smallest)
                  $display("%0t: smallest exp %h got %h", $time, want.smallest,
                           got.smallest);
               if (got.largest != want.largest)
                  $display("%0t: largest exp %h got %h", $time, want.largest, got.largest);
               if (got.mean != want.mean)
                  $display("%0t: mean exp %h got %h", $time, want.mean, got.mean);
               if (got != want) fail_count++;
            end
         end
         if (req_valid && !req_stall)
            summary_q.insert(summary_q.size(),
                             apply_action(req_action, req_value, req_position));
      end
      pending = summary_q.size();
   end

endmodule

// ===== tb/tb_indexed_list_with_stats.sv =====
module tb_indexed_list_with_stats;

   localparam int WATCHDOG_LIMIT = 5000;

   logic        clock;
   logic        reset;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_action = '0;
   logic [31:0] req_value = '0;
   logic [4:0]  req_position = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_read_value;
   logic [3:0]  rsp_found_position;
   logic [4:0]  rsp_count;
   logic [35:0] rsp_total;
   logic [31:0] rsp_smallest;
   logic [31:0] rsp_largest;
   logic [31:0] rsp_mean;
   int          fail_count;
   int          pending;
   int          idle_cycles = 0;
   int          beats_sent = 0;
   int          beats_taken = 0;
   bit          stall_free = 1'b0;

   indexed_list_with_stats i_dut (.*);

   tb_ilws_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (rsp_valid && !rsp_stall) beats_taken <= beats_taken + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
         $display("FAIL indexed_list_with_stats");
         $finish;
      end
   end

   // result side stall, drawn per beat
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         gap = stall_free ? 0 : $urandom_range(0, 8);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_beat(logic [3:0] act, logic [31:0] v, logic [4:0] pos, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= v;
      req_position <= pos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return '1;
         2: return $urandom_range(0, 7);
         default: return $urandom;
      endcase
   endfunction

   initial begin
      int act;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty cases, extremes, fill to full, bad indexes, unknown actions
      send_beat(ilws_pkg::ACT_POP_FRONT, '0, '0, 0);
      send_beat(ilws_pkg::ACT_POP_BACK, '0, '0, 0);
      send_beat(ilws_pkg::ACT_REMOVE, '0, 5'd0, 0);
      send_beat(ilws_pkg::ACT_READ, '0, 5'd0, 0);
      send_beat(ilws_pkg::ACT_SEARCH, 32'hFFFF_FFFF, '0, 0);
      send_beat(ilws_pkg::ACT_INSERT, 32'd1, 5'd1, 0);
      for (int k = 0; k < ilws_pkg::DEPTH; k++)
         send_beat(k[0] ? ilws_pkg::ACT_PUSH_FRONT : ilws_pkg::ACT_PUSH_BACK,
                   32'(32'hFFFF_FFFF - k), '0, 0);
      send_beat(ilws_pkg::ACT_PUSH_BACK, 32'h0, '0, 0);
      send_beat(ilws_pkg::ACT_INSERT, 32'h0, 5'd16, 0);
      send_beat(ilws_pkg::ACT_READ, '0, 5'd16, 1);
      send_beat(ilws_pkg::ACT_READ, '0, 5'd31, 1);
      send_beat(ilws_pkg::ACT_SEARCH, 32'hFFFF_FFF0, '0, 1);
      send_beat(ilws_pkg::ACT_REMOVE, '0, 5'd15, 1);
      send_beat(4'd15, '0, '0, 1);
      send_beat(ilws_pkg::ACT_CLEAR, '0, '0, 1);

      // hold off until the block has drained
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);

      for (int n = 0; n < 950; n++) begin
         stall_free = (n >= 400 && n < 460);
         act = $urandom_range(0, 99);
         if (act < 40)
            send_beat(4'($urandom_range(0, 2)), pick_value(), 5'($urandom_range(0, 17)),
                      !stall_free);
         else if (act < 70)
            send_beat(4'($urandom_range(3, 5)), pick_value(), 5'($urandom_range(0, 17)),
                      !stall_free);
         else if (act < 93)
            send_beat(4'($urandom_range(6, 7)), pick_value(), 5'($urandom_range(0, 31)),
                      !stall_free);
         else if (act < 96)
            send_beat(ilws_pkg::ACT_CLEAR, $urandom, 5'($urandom), !stall_free);
         else
            send_beat(4'($urandom_range(9, 15)), $urandom, 5'($urandom), !stall_free);
      end
      req_valid <= 1'b0;

      while (beats_taken < beats_sent) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d actions over all opcodes, full, empty and bad index cases",
               beats_sent);
      $display("checked %0d result beats under random gaps and stalls", beats_taken);
      if (fail_count == 0 && pending == 0)
         $display("PASS indexed_list_with_stats");
      else
         $display("FAIL indexed_list_with_stats");
      $finish;
   end

endmodule
